// ----- rtl/core/smpws_pkg.sv -----
// ----------------------------------------------------------------------------
// smpws_pkg
// Types, constants and helpers shared by the straight-move profile block.
// ----------------------------------------------------------------------------
package smpws_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int DUTY_W         = 8;
  localparam int ZONE_W         = 16;
  localparam int DIST_W         = 16;
  localparam int ENC_W          = 32;
  localparam int PHASE_W        = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int S_TDATA_W      = 80;
  localparam int M_TDATA_W      = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DUTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CREEP_DUTY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_FLOOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ZONE   = 2'd3;

  // Register values after reset.
  localparam logic [DUTY_W-1:0] CRUISE_DUTY_RST = 8'd100;
  localparam logic [DUTY_W-1:0] CREEP_DUTY_RST  = 8'd27;
  localparam logic [DUTY_W-1:0] DECEL_FLOOR_RST = 8'd30;
  localparam logic [ZONE_W-1:0] SLOW_ZONE_RST   = 16'd5;

  // Balance limit sits this far above the cruise duty.
  localparam logic [DUTY_W:0] BAL_MARGIN = 9'd5;
  localparam logic [DUTY_W-1:0] RAMP_STEP  = 8'd1;
  localparam logic [DUTY_W-1:0] DECEL_STEP = 8'd2;
  localparam logic [DUTY_W-1:0] TRIM_STEP  = 8'd1;

  // Phase codes as reported on the result stream.
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RAMP   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CREEP  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RAMP   = 5'b00010,
    ST_CRUISE = 5'b00100,
    ST_DECEL  = 5'b01000,
    ST_CREEP  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [DUTY_W-1:0] cruise_duty;
    logic [DUTY_W-1:0] creep_duty;
    logic [DUTY_W-1:0] decel_floor;
    logic [ZONE_W-1:0] slow_zone;
  } cfg_t;

  typedef struct packed {
    logic                     func;
    logic signed [DIST_W-1:0] distance;
    logic signed [ENC_W-1:0]  left_count;
    logic signed [ENC_W-1:0]  right_count;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [DUTY_W-1:0]  right_duty;
    logic [DUTY_W-1:0]  left_duty;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      ST_RAMP:   code = PH_RAMP;
      ST_CRUISE: code = PH_CRUISE;
      ST_DECEL:  code = PH_DECEL;
      ST_CREEP:  code = PH_CREEP;
      default:   code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/smpws_in_stage.sv -----
// ----------------------------------------------------------------------------
// smpws_in_stage
// Input register: captures one item from the slave stream and holds it until
// the control pass takes it.
// ----------------------------------------------------------------------------
module smpws_in_stage (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [smpws_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 advance,
  output logic                                 item_valid,
  output smpws_pkg::item_t                     item
);
  import smpws_pkg::*;

  logic  valid;
  item_t data;

  // The stage frees up in the same cycle that its item moves on.
  assign s_tready   = !valid || advance;
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data.func        <= s_tuser;
      data.distance    <= s_tdata[15:0];
      data.left_count  <= s_tdata[47:16];
      data.right_count <= s_tdata[79:48];
    end
  end

endmodule

// ----- rtl/core/smpws_pass.sv -----
// ----------------------------------------------------------------------------
// smpws_pass
// Move state and the single control pass run for each item: start latch,
// phase fall-through and wheel balance.
// ----------------------------------------------------------------------------
module smpws_pass #(
  parameter int COUNT_BITS = smpws_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  smpws_pkg::cfg_t      cfg,
  input  smpws_pkg::item_t     item,
  output smpws_pkg::result_t   res
);
  import smpws_pkg::*;

  localparam int CW = COUNT_BITS;

  logic signed [CW-1:0] left_start, right_start, left_target;
  logic [DUTY_W-1:0]    left_speed, right_speed, left_drive, right_drive;
  phase_t               move_phase;

  logic signed [CW-1:0] left_start_next, right_start_next, left_target_next;
  logic [DUTY_W-1:0]    left_speed_next, right_speed_next;
  logic [DUTY_W-1:0]    left_drive_next, right_drive_next;
  phase_t               move_phase_next;

  logic signed [CW-1:0] lc, rc, dl, dr;
  logic signed [CW+1:0] to_go, bal_diff, zone;
  logic [DUTY_W:0]      speed_sum, limit;
  logic                 ramp_on, cruise_on, ahead, decel_on;
  logic                 balance, done, left_lag, right_lag;

  // Counts are brought to the working width: sign-extended or wrapped.
  assign lc = CW'(item.left_count);
  assign rc = CW'(item.right_count);

  assign dl = lc - left_start;
  assign dr = rc - right_start;

  // Exact distances, two bits wider than the counts so nothing wraps.
  assign to_go    = (CW+2)'(left_target) - (CW+2)'(lc);
  assign bal_diff = (CW+2)'(dr) - (CW+2)'(dl);
  assign zone     = $signed((CW+2)'(cfg.slow_zone));

  assign speed_sum = {1'b0, left_speed} + {1'b0, right_speed};
  assign ramp_on   = speed_sum[DUTY_W:1] < cfg.cruise_duty;
  assign cruise_on = to_go > zone;
  assign ahead     = to_go > $signed((CW+2)'(0));
  assign decel_on  = ahead && (left_speed > cfg.decel_floor);
  assign limit     = {1'b0, cfg.cruise_duty} + BAL_MARGIN;
  assign left_lag  = bal_diff > $signed((CW+2)'(1));
  assign right_lag = bal_diff < $signed(-(CW+2)'(1));

  always_comb begin
    left_start_next  = left_start;
    right_start_next = right_start;
    left_target_next = left_target;
    left_speed_next  = left_speed;
    right_speed_next = right_speed;
    left_drive_next  = left_drive;
    right_drive_next = right_drive;
    move_phase_next  = move_phase;
    balance          = 1'b0;
    done             = 1'b0;

    if (item.func) begin
      left_start_next  = lc;
      right_start_next = rc;
      left_target_next = lc + CW'(item.distance);
      left_speed_next  = '0;
      right_speed_next = '0;
      move_phase_next  = ST_RAMP;
    end else begin
      // Phases whose condition already fails fall through in the same pass.
      if (move_phase_next == ST_RAMP) begin
        if (ramp_on) begin
          left_speed_next  = left_speed_next + RAMP_STEP;
          right_speed_next = right_speed_next + RAMP_STEP;
          balance          = 1'b1;
          done             = 1'b1;
        end else begin
          move_phase_next = ST_CRUISE;
        end
      end
      if (!done && move_phase_next == ST_CRUISE) begin
        if (cruise_on) begin
          balance = 1'b1;
          done    = 1'b1;
        end else begin
          move_phase_next = ST_DECEL;
        end
      end
      if (!done && move_phase_next == ST_DECEL) begin
        if (decel_on) begin
          left_speed_next  = left_speed_next - DECEL_STEP;
          right_speed_next = right_speed_next - DECEL_STEP;
          balance          = 1'b1;
          done             = 1'b1;
        end else begin
          move_phase_next = ST_CREEP;
        end
      end
      if (!done && move_phase_next == ST_CREEP) begin
        done = 1'b1;
        if (ahead) begin
          left_drive_next  = cfg.creep_duty;
          right_drive_next = cfg.creep_duty;
        end else begin
          left_drive_next  = '0;
          right_drive_next = '0;
          move_phase_next  = ST_IDLE;
        end
      end
      if (!done) begin
        move_phase_next = ST_IDLE;
      end
      if (balance) begin
        // Speed up the lagging wheel unless it is already over the limit,
        // in which case its partner is slowed instead.
        if (left_lag) begin
          if ({1'b0, left_speed_next} > limit) begin
            right_speed_next = right_speed_next - TRIM_STEP;
          end else begin
            left_speed_next = left_speed_next + TRIM_STEP;
          end
        end else if (right_lag) begin
          if ({1'b0, right_speed_next} > limit) begin
            left_speed_next = left_speed_next - TRIM_STEP;
          end else begin
            right_speed_next = right_speed_next + TRIM_STEP;
          end
        end
        left_drive_next  = left_speed_next;
        right_drive_next = right_speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_start  <= '0;
      right_start <= '0;
      left_target <= '0;
      left_speed  <= '0;
      right_speed <= '0;
      left_drive  <= '0;
      right_drive <= '0;
      move_phase  <= ST_IDLE;
    end else if (fire) begin
      left_start  <= left_start_next;
      right_start <= right_start_next;
      left_target <= left_target_next;
      left_speed  <= left_speed_next;
      right_speed <= right_speed_next;
      left_drive  <= left_drive_next;
      right_drive <= right_drive_next;
      move_phase  <= move_phase_next;
    end
  end

  assign res.left_duty  = left_drive_next;
  assign res.right_duty = right_drive_next;
  assign res.phase      = phase_code(move_phase_next);

endmodule

// ----- rtl/core/smpws_out_stage.sv -----
// ----------------------------------------------------------------------------
// smpws_out_stage
// Result register feeding the master stream; holds a result while the
// receiver stalls.
// ----------------------------------------------------------------------------
module smpws_out_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  smpws_pkg::result_t                 res,
  output logic                               free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [smpws_pkg::M_TDATA_W-1:0]    m_tdata
);
  import smpws_pkg::*;

  logic    valid;
  result_t data;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {5'b0, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// ----- rtl/core/straight_move_profile_with_wheel_sync_core.sv -----
// ----------------------------------------------------------------------------
// straight_move_profile_with_wheel_sync_core
// Straight-move speed profile for a two-wheel drive with encoder balance.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream: s_tuser is the function (start move or
// tick) and s_tdata carries the distance and both encoder counts. Each item
// gives exactly one result on the master stream: both motor duties and the
// phase the move is in after the item.
// The item sits in the input register while the control pass runs, and the
// result register is loaded from the pass once that register is free; the
// result is valid from there. One item is taken every cycle while the
// receiver keeps up; the pass is combinational compares and small adds.
// When the receiver stalls, the result register holds its value and the
// input register still takes one more item, so the slave side stops only
// once both stages are full.
// Configuration writes land at the edge where cfg_we is high and should
// only be made while no item is in flight.
// Reset (rst, synchronous) empties both stages, sets the phase to idle,
// clears duties, start counts and target, and loads the register defaults.
// ----------------------------------------------------------------------------
module straight_move_profile_with_wheel_sync_core #(
  parameter int COUNT_BITS = smpws_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // fields from bit 0: distance[15:0], left_count[47:16], right_count[79:48]
  input  logic [smpws_pkg::S_TDATA_W-1:0]    s_tdata,
  // fields from bit 0: func
  input  logic                               s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // fields from bit 0: left_duty[7:0], right_duty[15:8], phase[18:16]
  output logic [smpws_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [smpws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smpws_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smpws_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    item_valid, out_free, advance;

  assign advance = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_duty <= CRUISE_DUTY_RST;
      cfg.creep_duty  <= CREEP_DUTY_RST;
      cfg.decel_floor <= DECEL_FLOOR_RST;
      cfg.slow_zone   <= SLOW_ZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRUISE_DUTY: cfg.cruise_duty <= cfg_data[DUTY_W-1:0];
        REG_CREEP_DUTY:  cfg.creep_duty  <= cfg_data[DUTY_W-1:0];
        REG_DECEL_FLOOR: cfg.decel_floor <= cfg_data[DUTY_W-1:0];
        REG_SLOW_ZONE:   cfg.slow_zone   <= cfg_data[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  smpws_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  smpws_pass #(
    .COUNT_BITS (COUNT_BITS)
  ) u_pass (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

  smpws_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/smpws_checker.sv -----
// ----------------------------------------------------------------------------
// smpws_checker
// Port-level checks on the straight-move profile block, bound to its top.
// ----------------------------------------------------------------------------
module smpws_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic [smpws_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready
);
  import smpws_pkg::*;

  // Both stages are empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("stages not empty after reset");

  // A stalled result must not change.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Whenever the block reports idle, the motors are stopped.
  a_idle_stopped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18:16] == PH_IDLE |-> m_tdata[15:0] == 16'd0)
    else $error("idle phase with non-zero duty");

  // Creep drives the same duty on both wheels.
  a_creep_equal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18:16] == PH_CREEP |-> m_tdata[7:0] == m_tdata[15:8])
    else $error("unequal duties in creep");

endmodule

bind straight_move_profile_with_wheel_sync_core smpws_checker u_smpws_checker (.*);

// ----- dv/tb_straight_move_profile_with_wheel_sync_core.sv -----
// ----------------------------------------------------------------------------
// tb_straight_move_profile_with_wheel_sync_core
// Self-checking bench for the straight-move profile with wheel balance.
// ----------------------------------------------------------------------------
// A queue of items fed by the stimulus process drives the slave stream; every
// accepted transfer is run through a local model of the profile and the
// predicted duties and phase are queued. The monitor compares each result
// transfer with the oldest prediction. Both sides insert random gaps. The run
// covers a short directed sequence and then random moves under several
// register settings, including all-zero and all-ones.
// ----------------------------------------------------------------------------
module tb_straight_move_profile_with_wheel_sync_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smpws_pkg::*;

  logic                  clk;
  logic                  rst;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  straight_move_profile_with_wheel_sync_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model copy of the registers.
  logic [DUTY_W-1:0] cfg_speed;
  logic [DUTY_W-1:0] cfg_creep;
  logic [DUTY_W-1:0] cfg_floor;
  logic [ZONE_W-1:0] cfg_zone;

  // Model copy of the move state.
  int                 base_left;
  int                 base_right;
  int                 aim_left;
  logic [DUTY_W-1:0]  work_left;
  logic [DUTY_W-1:0]  work_right;
  logic [DUTY_W-1:0]  out_left;
  logic [DUTY_W-1:0]  out_right;
  logic [PHASE_W-1:0] move_ph;

  item_t   item_backlog[$];
  result_t duty_exp[$];
  item_t   cur_item;

  int n_pushed;
  int n_done;
  int n_err;
  int feed_gap;
  int sink_stall;
  bit no_gaps;

  // Exact signed test: a lies below b by more than gap.
  function automatic bit trails(longint a, longint b, longint gap);
    return (b - a) > gap;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Wheel balance: the lagging wheel is sped up unless it is already well
  // above the cruise duty, in which case its partner is slowed instead.
  function automatic void balance_wheels(int lc, int rc);
    int dl;
    int dr;
    int lim;
    dl  = lc - base_left;
    dr  = rc - base_right;
    lim = int'(cfg_speed) + int'(BAL_MARGIN);
    if (trails(dl, dr, 1)) begin
      if (int'(work_left) > lim) work_right = work_right - TRIM_STEP;
      else work_left = work_left + TRIM_STEP;
    end else if (trails(dr, dl, 1)) begin
      if (int'(work_right) > lim) work_left = work_left - TRIM_STEP;
      else work_right = work_right + TRIM_STEP;
    end
    out_left  = work_left;
    out_right = work_right;
  endfunction

  function automatic result_t drive_pass(item_t it);
    result_t res;
    int      lc;
    int      rc;
    bit      done;
    lc   = it.left_count;
    rc   = it.right_count;
    done = 1'b0;
    if (it.func) begin
      base_left  = lc;
      base_right = rc;
      aim_left   = lc + int'(it.distance);
      work_left  = '0;
      work_right = '0;
      move_ph    = PH_RAMP;
    end else begin
      // Phases whose condition already fails fall through in the same pass.
      if (move_ph == PH_RAMP) begin
        if ((int'(work_left) + int'(work_right)) / 2 < int'(cfg_speed)) begin
          work_left  = work_left + RAMP_STEP;
          work_right = work_right + RAMP_STEP;
          balance_wheels(lc, rc);
          done = 1'b1;
        end else begin
          move_ph = PH_CRUISE;
        end
      end
      if (!done && move_ph == PH_CRUISE) begin
        if (trails(lc, aim_left, longint'(cfg_zone))) begin
          balance_wheels(lc, rc);
          done = 1'b1;
        end else begin
          move_ph = PH_DECEL;
        end
      end
      if (!done && move_ph == PH_DECEL) begin
        if (trails(lc, aim_left, 0) && work_left > cfg_floor) begin
          work_left  = work_left - DECEL_STEP;
          work_right = work_right - DECEL_STEP;
          balance_wheels(lc, rc);
          done = 1'b1;
        end else begin
          move_ph = PH_CREEP;
        end
      end
      if (!done && move_ph == PH_CREEP) begin
        out_left  = cfg_creep;
        out_right = cfg_creep;
        if (!trails(lc, aim_left, 0)) begin
          out_left  = '0;
          out_right = '0;
          move_ph   = PH_IDLE;
        end
        done = 1'b1;
      end
      if (!done) move_ph = PH_IDLE;
    end
    res.left_duty  = out_left;
    res.right_duty = out_right;
    res.phase      = move_ph;
    return res;
  endfunction

  // Input side: accepted transfers are predicted, then the next item is offered.
  always @(posedge clk) begin : feed_proc
    if (rst) begin
      s_tvalid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        duty_exp.push_back(drive_pass(cur_item));
        if (!no_gaps && $urandom_range(0, 3) == 0) feed_gap = pick_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_tvalid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          s_tdata  <= {cur_item.right_count, cur_item.left_count, cur_item.distance};
          s_tuser  <= cur_item.func;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare every transfer with the oldest prediction.
  always @(posedge clk) begin : sink_proc
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_done++;
        if (duty_exp.size() == 0) begin
          if (n_err < 10)
            $display("%0t: result with nothing expected: left %0d right %0d phase %0d",
                     $realtime, m_tdata[7:0], m_tdata[15:8], m_tdata[18:16]);
          n_err++;
        end else begin
          want = duty_exp.pop_front();
          if (m_tdata[7:0] !== want.left_duty || m_tdata[15:8] !== want.right_duty ||
              m_tdata[18:16] !== want.phase) begin
            if (n_err < 10)
              $display("%0t: mismatch: expected left %0d right %0d phase %0d, got %0d %0d %0d",
                       $realtime, want.left_duty, want.right_duty, want.phase,
                       m_tdata[7:0], m_tdata[15:8], m_tdata[18:16]);
            n_err++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 4) == 0) sink_stall = pick_gap();
      end
    end
  end

  task automatic push_item(bit f, shortint d, int lc, int rc);
    item_t it;
    it.func        = f;
    it.distance    = d;
    it.left_count  = lc;
    it.right_count = rc;
    item_backlog.push_back(it);
    n_pushed++;
  endtask

  task automatic push_noise();
    push_item(1'($urandom_range(0, 1)), shortint'($urandom), $urandom, $urandom);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CRUISE_DUTY: cfg_speed = val[DUTY_W-1:0];
      REG_CREEP_DUTY:  cfg_creep = val[DUTY_W-1:0];
      REG_DECEL_FLOOR: cfg_floor = val[DUTY_W-1:0];
      REG_SLOW_ZONE:   cfg_zone  = val[ZONE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [7:0] spd, logic [7:0] crp, logic [7:0] flr,
                           logic [15:0] zone);
    // Upper bits of the 8-bit registers carry junk that must be dropped.
    write_reg(REG_CRUISE_DUTY, {8'($urandom), spd});
    write_reg(REG_CREEP_DUTY, {8'($urandom), crp});
    write_reg(REG_DECEL_FLOOR, {8'($urandom), flr});
    write_reg(REG_SLOW_ZONE, zone);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (n_done != n_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One move: a start and then ticks where both counts creep forward, the
  // right wheel with a drift of its own, now and then a stray item mixed in.
  task automatic queue_move();
    int lc;
    int rc;
    int n;
    int drift;
    shortint d;
    case ($urandom_range(0, 7))
      0:       lc = 32'h7fffff00 + $urandom_range(0, 255);
      1:       lc = 32'h80000000 + $urandom_range(0, 255);
      2:       lc = $urandom;
      default: lc = int'($urandom_range(0, 2000)) - 1000;
    endcase
    if ($urandom_range(0, 3) == 0) rc = $urandom;
    else rc = lc + int'($urandom_range(0, 20)) - 10;
    n = int'(cfg_speed) + int'($urandom_range(4, 40));
    case ($urandom_range(0, 9))
      0:       d = -shortint'($urandom_range(0, 50));
      1:       d = shortint'($urandom);
      default: d = shortint'($urandom_range(0, 2 * n));
    endcase
    drift = int'($urandom_range(0, 2)) - 1;
    push_item(1'b1, d, lc, rc);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        push_noise();
      end else begin
        lc += $urandom_range(0, 3);
        rc += int'($urandom_range(0, 3)) + drift;
        push_item(1'b0, shortint'($urandom), lc, rc);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    m_tready  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    n_pushed  = 0;
    n_done    = 0;
    n_err     = 0;
    no_gaps   = 1'b0;
    cfg_speed = CRUISE_DUTY_RST;
    cfg_creep = CREEP_DUTY_RST;
    cfg_floor = DECEL_FLOOR_RST;
    cfg_zone  = SLOW_ZONE_RST;
    base_left  = 0;
    base_right = 0;
    aim_left   = 0;
    work_left  = '0;
    work_right = '0;
    out_left   = '0;
    out_right  = '0;
    move_ph    = PH_IDLE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: a short profile run from ramp through cruise and decel to idle, small cruise duty.
    load_regs(8'd6, 8'd200, 8'd2, 16'd10);
    push_item(1'b0, 16'sh8000, 32'h7fffffff, 32'h80000000);  // tick while idle
    push_item(1'b1, 16'sd20, 0, 0);
    push_item(1'b0, 0, 0, 0);
    push_item(1'b0, 0, 0, 3);    // right ahead, left is sped up
    push_item(1'b0, 0, 3, 0);    // left ahead, right is sped up
    push_item(1'b0, 0, 1, 1);
    push_item(1'b0, 0, 2, 2);
    push_item(1'b0, 0, 3, 3);
    // Right well ahead in cruise until the left duty passes the limit.
    for (int k = 0; k < 8; k++) push_item(1'b0, 0, 4, 9 + k);
    push_item(1'b0, 0, 12, 12);  // inside the slow zone
    push_item(1'b0, 0, 12, 12);
    push_item(1'b0, 0, 13, 13);
    push_item(1'b0, 0, 19, 19);  // one count short, still in decel
    push_item(1'b0, 0, 20, 20);  // target reached
    push_item(1'b0, 0, 25, 25);
    push_item(1'b1, -16'sd5, 100, 100);  // backwards distance
    push_item(1'b0, 0, 100, 100);
    push_item(1'b1, 16'sd32767, 32'h7ffffff0, 32'h7ffffff0);  // restart, target wraps
    push_item(1'b0, 0, 32'h7ffffff8, 32'h7ffffff8);
    push_item(1'b1, -16'sd32768, 32'h80000010, 32'h80000010);
    push_item(1'b0, 0, 32'h80000020, 32'h80000010);
    settle();

    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      int mark;
      logic [7:0] spd;
      case (ph_i)
        0: load_regs(CRUISE_DUTY_RST, CREEP_DUTY_RST, DECEL_FLOOR_RST, SLOW_ZONE_RST);
        1: load_regs(8'd0, 8'd0, 8'd0, 16'd0);
        2: load_regs(8'hff, 8'hff, 8'hff, 16'hffff);
        default: begin
          spd = 8'($urandom_range(0, 24));
          load_regs(spd, 8'($urandom), 8'($urandom_range(0, int'(spd) + 2)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 40)));
        end
      endcase
      no_gaps = (ph_i == 4);
      mark = n_pushed;
      while (n_pushed - mark < 50) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) push_noise();
        end else begin
          queue_move();
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (duty_exp.size() != 0) begin
      $display("%0d expected results never arrived", duty_exp.size());
      n_err += duty_exp.size();
    end
    if (n_err == 0) begin
      $display("straight_move_profile_with_wheel_sync_core verification clean");
    end else begin
      $display("straight_move_profile_with_wheel_sync_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("straight_move_profile_with_wheel_sync_core verification failed");
    $finish;
  end

endmodule
